[src/jlbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlbc_pkg
// Shared types and constants for the joint limit barrier control core.
// ----------------------------------------------------------------------------
package jlbc_pkg;

    localparam int DATA_W    = 32;            // position, limits, gain, drive
    localparam int DIFF_W    = 33;            // position to limit distances
    localparam int LOG_FRAC  = 26;            // fraction bits of log2 result
    localparam int LOG_INT_W = 6;             // integer bits of log2 result
    localparam int LOG_W     = LOG_INT_W + LOG_FRAC;
    localparam int PROD_W    = 64;            // gain times |ln|
    localparam int SUM_W     = 34;            // a + b, zero extended
    localparam int PP_W      = DATA_W + SUM_W;
    localparam int NUM_W     = 98;            // dividend width
    localparam int DEN_W     = 92;            // (a*b) << 26
    localparam int QUO_W     = 32;            // quotient bits below overflow
    localparam int DIV_LAT   = QUO_W + 1;
    localparam int LOG_LAT   = LOG_FRAC + 1;

    localparam logic [DATA_W-1:0] LN2_Q32    = 32'd2977044472;
    localparam logic [DATA_W-1:0] LOW_RST    = 32'hFFFC_DBC1;   // -205887
    localparam logic [DATA_W-1:0] HIGH_RST   = 32'h0003_243F;   //  205887
    localparam logic [DATA_W-1:0] GAIN_RST   = 32'h0006_8DB9;   //  429497
    localparam logic [DATA_W-1:0] DRIVE_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] DRIVE_MIN  = 32'h8000_0000;

    typedef enum logic [1:0] {
        CFG_LOW  = 2'd0,
        CFG_HIGH = 2'd1,
        CFG_GAIN = 2'd2
    } cfg_index_t;

    // per item flags that ride along the pipeline
    typedef struct packed {
        logic oor;      // at or beyond a limit
        logic low;      // at or below the low limit
        logic neg;      // log2(a) > log2(b)
    } tag_t;

    // front stage result
    typedef struct packed {
        logic [DIFF_W-1:0] a;
        logic [DIFF_W-1:0] b;
        logic              oor;
        logic              low;
    } front_t;

endpackage

[src/jlbc_log2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlbc_log2
// Pipelined log2 in Q.26: normalize stage, then one squaring stage per
// fraction bit. Advances when en is high.
// ----------------------------------------------------------------------------
module jlbc_log2 import jlbc_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [DIFF_W-1:0] x,
    output logic [LOG_W-1:0]  log_q
);

    logic [LOG_INT_W-1:0] n_reg    [LOG_LAT];
    logic [DATA_W-1:0]    m_reg    [LOG_LAT];
    logic [LOG_FRAC-1:0]  frac_reg [LOG_LAT];

    logic [LOG_INT_W-1:0] lead;
    logic [DIFF_W-1:0]    norm;

    // leading one position and mantissa alignment to Q1.31
    always_comb begin
        lead = '0;
        for (int i = 0; i < DIFF_W; i++) begin
            if (x[i]) begin
                lead = LOG_INT_W'(i);
            end
        end
        norm = x << (LOG_INT_W'(DATA_W) - lead);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]    <= lead;
            m_reg[0]    <= norm[DIFF_W-1:1];
            frac_reg[0] <= '0;
        end
    end

    // one fraction bit per stage
    for (genvar k = 1; k < LOG_LAT; k++) begin : g_sq
        logic [2*DATA_W-1:0] sq;
        logic [DATA_W:0]     t;

        assign sq = m_reg[k-1] * m_reg[k-1];
        assign t  = sq[2*DATA_W-1:DATA_W-1];

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k]    <= n_reg[k-1];
                m_reg[k]    <= t[DATA_W] ? t[DATA_W:1] : t[DATA_W-1:0];
                frac_reg[k] <= {frac_reg[k-1][LOG_FRAC-2:0], t[DATA_W]};
            end
        end
    end

    assign log_q = {n_reg[LOG_LAT-1], frac_reg[LOG_LAT-1]};

endmodule

[src/jlbc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlbc_div
// Pipelined restoring divider: overflow check stage, then one quotient bit
// per stage, most significant first.
// ----------------------------------------------------------------------------
module jlbc_div import jlbc_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             ovf
);

    localparam int CMP_W = DEN_W + QUO_W;

    logic [NUM_W-1:0] rem_reg [DIV_LAT];
    logic [DEN_W-1:0] den_reg [DIV_LAT];
    logic [QUO_W-1:0] q_reg   [DIV_LAT];
    logic             ovf_reg [DIV_LAT];

    // quotient of 2^32 or more sets the overflow flag
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= {(CMP_W-NUM_W)'(0), num} >= {den, (QUO_W)'(0)};
        end
    end

    for (genvar j = 1; j < DIV_LAT; j++) begin : g_bit
        logic [CMP_W-1:0] t;
        logic             ge;

        assign t  = {(QUO_W)'(0), den_reg[j-1]} << (QUO_W - j);
        assign ge = {(CMP_W-NUM_W)'(0), rem_reg[j-1]} >= t;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= ge ? rem_reg[j-1] - t[NUM_W-1:0] : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                q_reg[j]   <= {q_reg[j-1][QUO_W-2:0], ge};
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    assign quo = q_reg[DIV_LAT-1];
    assign ovf = ovf_reg[DIV_LAT-1];

endmodule

[src/joint_limit_barrier_control_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_limit_barrier_control_core
// Barrier drive for one joint: -gain*(1/a+1/b)*ln(a/b) from a position.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one signed Q16.16 position per transfer. m_* returns one
//   result per position: the signed Q16.16 drive on m_tdata and the
//   out-of-range flag on m_tuser. Results leave in input order.
//   Limits and gain are written on cfg_* while no item is in flight.
// Throughput: one item per cycle while m_* is not stalled. The depth comes
//   from the two 26-stage squaring chains of the log2 units and the
//   33-stage restoring divider.
// Reset: aresetn low clears every valid bit and reloads the limits to
//   about +/-pi and the gain to about 1e-4.
// Stall: while m_tvalid is high and m_tready low, the whole pipeline
//   holds and s_tready is low; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module joint_limit_barrier_control_core import jlbc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration writes
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] position
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] drive
    output logic              m_tuser    // [0] out_of_range
);

    localparam int LAT = 1 + LOG_LAT + 5 + DIV_LAT + 1;

    logic [DATA_W-1:0] low_reg, high_reg, gain_reg;
    logic [LAT-1:0]    vld_reg;
    logic              en;

    // global advance
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= LOW_RST;
            high_reg <= HIGH_RST;
            gain_reg <= GAIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LOW:  low_reg  <= cfg_wdata;
                CFG_HIGH: high_reg <= cfg_wdata;
                CFG_GAIN: gain_reg <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    // valid bits travel with the items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // front: distances to both limits
    logic signed [DIFF_W:0] a_full, b_full;
    logic                   a_le0, b_le0;
    front_t                 f_reg;

    always_comb begin
        a_full = $signed({{2{s_tdata[DATA_W-1]}}, s_tdata})
               - $signed({{2{low_reg[DATA_W-1]}}, low_reg});
        b_full = $signed({{2{high_reg[DATA_W-1]}}, high_reg})
               - $signed({{2{s_tdata[DATA_W-1]}}, s_tdata});
        a_le0  = a_full[DIFF_W] || (a_full == '0);
        b_le0  = b_full[DIFF_W] || (b_full == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg.a   <= a_full[DIFF_W-1:0];
            f_reg.b   <= b_full[DIFF_W-1:0];
            f_reg.oor <= a_le0 || b_le0;
            f_reg.low <= a_le0;
        end
    end

    // log2 of both distances
    logic [LOG_W-1:0] la, lb;

    jlbc_log2 u_log_a (.aclk(aclk), .en(en), .x(f_reg.a), .log_q(la));
    jlbc_log2 u_log_b (.aclk(aclk), .en(en), .x(f_reg.b), .log_q(lb));

    // distances wait beside the log units
    front_t fd_reg [LOG_LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            fd_reg[0] <= f_reg;
            for (int k = 1; k < LOG_LAT; k++) begin
                fd_reg[k] <= fd_reg[k-1];
            end
        end
    end

    // E1..E5: |ln(a/b)|, gain product, dividend and divisor
    front_t             e1_f_reg, e2_f_reg, e3_f_reg;
    tag_t               e1_tag_reg, e2_tag_reg, e3_tag_reg, e4_tag_reg, e5_tag_reg;
    logic [LOG_W-1:0]   absd_reg;
    logic [DATA_W-1:0]  absl_reg;
    logic [PROD_W-1:0]  p_reg;
    logic [PP_W-1:0]    pp_lo_reg, pp_hi_reg, ab_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [2*DATA_W-1:0] absl_next;
    logic [SUM_W-1:0]   s_next;
    logic               neg_next;

    always_comb begin
        neg_next  = la > lb;
        absl_next = absd_reg * LN2_Q32;
        s_next    = {1'b0, e3_f_reg.a} + {1'b0, e3_f_reg.b};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // E1
            e1_f_reg       <= fd_reg[LOG_LAT-1];
            e1_tag_reg.oor <= fd_reg[LOG_LAT-1].oor;
            e1_tag_reg.low <= fd_reg[LOG_LAT-1].low;
            e1_tag_reg.neg <= neg_next;
            absd_reg       <= neg_next ? la - lb : lb - la;
            // E2
            e2_f_reg   <= e1_f_reg;
            e2_tag_reg <= e1_tag_reg;
            absl_reg   <= absl_next[2*DATA_W-1:DATA_W];
            // E3
            e3_f_reg   <= e2_f_reg;
            e3_tag_reg <= e2_tag_reg;
            p_reg      <= gain_reg * absl_reg;
            // E4: partial products of the dividend, divisor product
            e4_tag_reg <= e3_tag_reg;
            pp_lo_reg  <= p_reg[DATA_W-1:0] * s_next;
            pp_hi_reg  <= p_reg[PROD_W-1:DATA_W] * s_next;
            ab_reg     <= {{(PP_W-DIFF_W){1'b0}}, e3_f_reg.a} * e3_f_reg.b;
            // E5
            e5_tag_reg <= e4_tag_reg;
            num_reg    <= NUM_W'(pp_lo_reg) + {pp_hi_reg, (DATA_W)'(0)};
            den_reg    <= DEN_W'({ab_reg[2*DATA_W-1:0], (LOG_FRAC)'(0)});
        end
    end

    // magnitude = num / den
    logic [QUO_W-1:0] quo;
    logic             ovf;

    jlbc_div u_div (
        .aclk (aclk),
        .en   (en),
        .num  (num_reg),
        .den  (den_reg),
        .quo  (quo),
        .ovf  (ovf)
    );

    tag_t td_reg [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            td_reg[0] <= e5_tag_reg;
            for (int k = 1; k < DIV_LAT; k++) begin
                td_reg[k] <= td_reg[k-1];
            end
        end
    end

    // sign, saturation and limit cases
    tag_t              tg;
    logic [DATA_W-1:0] drive_next;
    logic [DATA_W-1:0] drive_reg;
    logic              oor_reg;

    always_comb begin
        tg = td_reg[DIV_LAT-1];
        if (tg.oor) begin
            drive_next = tg.low ? DRIVE_MAX : DRIVE_MIN;
        end else if (tg.neg) begin
            drive_next = (ovf || quo[QUO_W-1]) ? DRIVE_MIN : (~quo + 1'b1);
        end else begin
            drive_next = (ovf || quo >= DRIVE_MAX) ? DRIVE_MAX : quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            drive_reg <= drive_next;
            oor_reg   <= tg.oor;
        end
    end

    assign m_tdata = drive_reg;
    assign m_tuser = oor_reg;

endmodule

[dv/jlbc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlbc_checker
// Watches the configuration port and both streams of the barrier control
// core, computes the expected drive and out-of-range flag for every accepted
// position and compares them with the results in order.
// ----------------------------------------------------------------------------
module jlbc_checker import jlbc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,
    input  logic              m_tuser,
    output int                errors,
    output int                pending,
    output int                results_seen,
    output int                oor_seen
);

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic              oor;
    } barrier_res_t;

    barrier_res_t     drive_q[$];
    logic signed [31:0] lim_lo, lim_hi;
    logic [31:0]      gain_r;

    // log2 in Q.26 of a positive value below 2^40
    function automatic logic [63:0] log2_fix(input logic [63:0] x);
        int          msb;
        logic [63:0] m, fr;
        msb = 0;
        fr  = 0;
        for (int k = 0; k < 64; k++)
            if (x[k]) msb = k;
        m = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
        for (int r = 0; r < LOG_FRAC; r++) begin
            m  = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000) begin
                m  = m >> 1;
                fr = fr | 1;
            end
        end
        return (64'(msb) << LOG_FRAC) | fr;
    endfunction

    function automatic barrier_res_t barrier_drive(input logic [31:0] pos_raw);
        barrier_res_t       res;
        logic signed [63:0] pos, da, db;
        logic [63:0]        la, lb, dif, absl, prod, mag;
        logic [191:0]       num, den;
        logic               neg;
        pos = 64'(signed'(pos_raw));
        da  = pos - 64'(lim_lo);
        db  = 64'(lim_hi) - pos;
        if (da <= 0 || db <= 0) begin
            res.oor   = 1'b1;
            res.drive = (da <= 0) ? DRIVE_MAX : DRIVE_MIN;
            return res;
        end
        la   = log2_fix(da);
        lb   = log2_fix(db);
        neg  = la > lb;
        dif  = neg ? la - lb : lb - la;
        absl = 64'((128'(dif) * 128'(LN2_Q32)) >> 32);
        prod = 64'(gain_r) * absl;
        num  = 192'(prod) * 192'(da + db);
        den  = (192'(da) * 192'(db)) << 26;
        mag  = (num >= (den << 32)) ? 64'h1_0000_0000 : 64'(num / den);
        res.oor = 1'b0;
        if (neg)
            res.drive = (mag >= 64'h8000_0000) ? DRIVE_MIN : 32'(-mag);
        else
            res.drive = (mag >= 64'h7FFF_FFFF) ? DRIVE_MAX : mag[31:0];
        return res;
    endfunction

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    assign pending = drive_q.size();

    // track registers, predict on input transfer, compare on result transfer
    always @(posedge aclk) begin
        barrier_res_t exp_r;
        if (!aresetn) begin
            lim_lo       <= signed'(LOW_RST);
            lim_hi       <= signed'(HIGH_RST);
            gain_r       <= GAIN_RST;
            errors       <= 0;
            results_seen <= 0;
            oor_seen     <= 0;
            drive_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                drive_q.push_back(barrier_drive(s_tdata));
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (m_tuser) oor_seen <= oor_seen + 1;
                if (drive_q.size() == 0) begin
                    report($sformatf("unexpected result %h/%b", m_tdata, m_tuser));
                end else begin
                    exp_r = drive_q.pop_front();
                    if (m_tdata !== exp_r.drive)
                        report($sformatf("drive %h, expected %h", m_tdata, exp_r.drive));
                    if (m_tuser !== exp_r.oor)
                        report($sformatf("out_of_range %b, expected %b",
                                         m_tuser, exp_r.oor));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LOW:  lim_lo <= signed'(cfg_wdata);
                    CFG_HIGH: lim_hi <= signed'(cfg_wdata);
                    CFG_GAIN: gain_r <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

[dv/tb_joint_limit_barrier_control_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joint_limit_barrier_control_core
// Drives positions through the barrier core under several limit and gain
// settings with random idling on both streams; the checker scores results.
// ----------------------------------------------------------------------------
module tb_joint_limit_barrier_control_core;
    import jlbc_pkg::*;

    localparam int DRAIN_CYCLES = 100;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [DATA_W-1:0] cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tuser;
    int                errors, pending, results_seen, oor_seen;
    bit                calm = 1'b0;
    logic signed [31:0] cur_lo, cur_hi;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    joint_limit_barrier_control_core dut (.*);

    jlbc_checker u_checker (.*);

    // result side back-pressure in bursts
    initial begin
        int n;
        forever begin
            n = $urandom_range(1, 18);
            repeat (n) @(posedge aclk) m_tready <= calm ? 1'b1 : ($urandom_range(0, 2) != 0);
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 18);
                repeat (n) @(posedge aclk) m_tready <= calm;
            end
        end
    end

    task automatic cfg_write(input cfg_index_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_limits(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [31:0] g);
        cfg_write(CFG_LOW, lo);
        cfg_write(CFG_HIGH, hi);
        cfg_write(CFG_GAIN, g);
        cur_lo = signed'(lo);
        cur_hi = signed'(hi);
    endtask

    // one position transfer, optional idle burst first
    task automatic send_pos(input logic [31:0] pos);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // mostly positions inside the limits, some near edges, some anywhere
    function automatic logic [31:0] rand_pos();
        logic signed [63:0] span, off;
        int sel;
        sel  = $urandom_range(0, 9);
        span = 64'(cur_hi) - 64'(cur_lo);
        if (sel == 0 || span <= 1) return $urandom();
        if (sel == 1) return 32'(64'(cur_lo) + $urandom_range(0, 3));
        if (sel == 2) return 32'(64'(cur_hi) - $urandom_range(0, 3));
        off = 64'({$urandom(), $urandom()} % 64'(span - 1)) + 1;
        return 32'(64'(cur_lo) + off);
    endfunction

    initial begin
        logic [31:0] gains[6];
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        cur_lo = signed'(LOW_RST);
        cur_hi = signed'(HIGH_RST);

        // directed: reset setting, edges, center, extremes
        send_pos(32'h0);
        send_pos(LOW_RST);
        send_pos(LOW_RST + 1);
        send_pos(HIGH_RST);
        send_pos(HIGH_RST - 1);
        send_pos(32'h8000_0000);
        send_pos(32'h7FFF_FFFF);
        send_pos(32'h0001_0000);
        send_pos(32'hFFFF_0000);
        send_pos(32'hFFFF_FFFF);
        settle();
        // widest limits, largest gain
        set_limits(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_pos(32'h8000_0000);
        send_pos(32'h8000_0001);
        send_pos(32'h7FFF_FFFE);
        send_pos(32'h7FFF_FFFF);
        send_pos(32'h0);
        send_pos(32'h5555_5555);
        settle();
        // zero gain, then unordered limits, then an ignored index
        set_limits(32'hFFFF_0000, 32'h0001_0000, 32'h0);
        send_pos(32'h0000_8000);
        send_pos(32'hFFFF_0000);
        send_pos(32'hFFFF_0001);
        settle();
        set_limits(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678);
        send_pos(32'h0);
        send_pos(32'h0002_0000);
        send_pos(32'hFFFE_0000);
        settle();
        cfg_write(cfg_index_t'(2'd3), 32'hDEAD_BEEF);

        // random phases with varied limits and gains
        gains = '{32'h0, 32'h1, 32'hFFFF_FFFF, GAIN_RST, 32'h8000_0000, 32'h0};
        for (int ph = 0; ph < 8; ph++) begin
            logic [31:0] lo, hi, g;
            case (ph)
                0: begin lo = LOW_RST; hi = HIGH_RST; end
                1: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
                2: begin lo = 32'h0; hi = 32'h4; end
                3: begin lo = $urandom(); hi = $urandom(); end
                default: begin
                    lo = 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
                    hi = lo + $urandom_range(2, 32'h0010_0000);
                end
            endcase
            g = (ph < 6) ? gains[ph] : $urandom();
            set_limits(lo, hi, g);
            if (ph == 7) calm = 1'b1;
            repeat (178) send_pos(rand_pos());
            settle();
        end

        $display("covered %0d results, %0d of them out of range, over 12 settings",
                 results_seen, oor_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
src/jlbc_pkg.sv
src/jlbc_log2.sv
src/jlbc_div.sv
src/joint_limit_barrier_control_core.sv
dv/jlbc_checker.sv
dv/tb_joint_limit_barrier_control_core.sv
